// ===== hw/rtl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [7:0]  BLANK_ATTR   = 8'h0F;
    localparam logic [7:0]  ATTR_RESET   = 8'h0F;
    localparam logic [15:0] BLANK_CELL   = {BLANK_ATTR, SPACE_CODE};

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic [6:0] read_col;
        logic [4:0] read_row;
    } tcw_in_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_pos;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic        scrolled;
    } tcw_out_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [15:0]       wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } tcw_ram_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcw_cell_ram.sv =====
`default_nettype none

module tcw_cell_ram (
    input  wire logic                 clk,
    input  wire tcw_pkg::tcw_ram_req_t req,
    output logic [15:0]                rdata
);

    logic [15:0] mem [tcw_pkg::CELLS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_pos_unit.sv =====
`default_nettype none

// Shared row-major address unit: row times the column count plus column.
module tcw_pos_unit (
    input  wire logic [tcw_pkg::ROW_W-1:0]  row,
    input  wire logic [tcw_pkg::COL_W-1:0]  col,
    output logic      [tcw_pkg::ADDR_W-1:0] pos
);

    localparam int AW = tcw_pkg::ADDR_W;

    assign pos = AW'(row) * tcw_pkg::ROW_STEP + AW'(col);

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_writer_core.sv =====
`default_nettype none

// Put, read and unused commands are accepted in S_IDLE and pass to S_DONE, where the result is
// registered once the output register is free; a new item is taken only after that result is registered.
// A scrolling put walks the cell memory through its one read port and one write port, moving
// each cell up a row and then blanking the bottom row. A clear blanks all ROWS * COLUMNS cells.
// After rst_n is released a clearing pass blanks all ROWS * COLUMNS cells;
// no item is accepted during it, though attribute writes are taken as ever.
module text_console_writer_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tcw_pkg::tcw_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tcw_pkg::tcw_out_t      out_data
);

    localparam int AW  = tcw_pkg::ADDR_W;
    localparam int CW  = tcw_pkg::COL_W;
    localparam int RW  = tcw_pkg::ROW_W;
    localparam int CW1 = CW + 1;
    localparam int RW1 = RW + 1;

    // Sequencer states.
    localparam logic [2:0] S_INIT    = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_CLEAR   = 3'd2;
    localparam logic [2:0] S_SCR_RD  = 3'd3;
    localparam logic [2:0] S_SCR_WR  = 3'd4;
    localparam logic [2:0] S_SCR_BLK = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [7:0]        attr_reg;
    logic              scr_reg, scr_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              out_valid_reg, out_valid_next;
    tcw_pkg::tcw_out_t out_data_reg, out_data_next;

    tcw_pkg::tcw_ram_req_t ram_req;
    logic [15:0]           ram_rdata;

    logic [RW-1:0] pu_row;
    logic [CW-1:0] pu_col;
    logic [AW-1:0] pu_pos;

    // The read coordinates are widened (the column by one bit, the row by two) so the range checks cannot wrap.
    logic       rd_in_range;

    logic [CW1-1:0] put_col;
    logic [RW1-1:0] put_row;

    assign rd_in_range = ({1'b0, in_data.read_col} < 8'(tcw_pkg::COLUMNS))
                      && ({2'b00, in_data.read_row} < 7'(tcw_pkg::ROWS));

    tcw_cell_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // The one address unit serves the put write, the cell read and the reported position.
    always_comb
    begin
        if (state_reg == S_IDLE && in_data.command == tcw_pkg::CMD_READ)
        begin
            pu_row = in_data.read_row[RW-1:0];
            pu_col = in_data.read_col[CW-1:0];
        end
        else
        begin
            pu_row = row_reg;
            pu_col = col_reg;
        end
    end

    tcw_pos_unit u_pos (
        .row (pu_row),
        .col (pu_col),
        .pos (pu_pos)
    );

    // Cursor after a put: a newline moves to the next row, a printed character steps right,
    // and stepping past the last column wraps to the next row.
    always_comb
    begin
        if (in_data.char_code == tcw_pkg::NEWLINE_CODE)
        begin
            put_col = '0;
            put_row = {1'b0, row_reg} + RW1'(1);
        end
        else
        begin
            put_col = {1'b0, col_reg} + CW1'(1);
            put_row = {1'b0, row_reg};
        end
        if (put_col >= CW1'(tcw_pkg::COLUMNS))
        begin
            put_col = '0;
            put_row = {1'b0, row_reg} + RW1'(1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        scr_next       = scr_reg;
        cmd_next       = cmd_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_data_next  = out_data_reg;
        ram_req        = '0;
        in_ready       = (state_reg == S_IDLE);

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = sweep_reg;
                ram_req.wdata = tcw_pkg::BLANK_CELL;
                if (sweep_reg == tcw_pkg::LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_data.command;
                    scr_next   = 1'b0;
                    rd_ok_next = 1'b0;
                    case (in_data.command)
                        tcw_pkg::CMD_PUT:
                        begin
                            if (in_data.char_code != tcw_pkg::NEWLINE_CODE)
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = pu_pos;
                                ram_req.wdata = {attr_reg, in_data.char_code};
                            end
                            if (put_row >= RW1'(tcw_pkg::ROWS))
                            begin
                                // Leaving the bottom row: scroll, cursor to bottom-left.
                                col_next   = '0;
                                row_next   = RW'(tcw_pkg::ROWS - 1);
                                scr_next   = 1'b1;
                                sweep_next = '0;
                                state_next = S_SCR_RD;
                            end
                            else
                            begin
                                col_next   = put_col[CW-1:0];
                                row_next   = put_row[RW-1:0];
                                state_next = S_DONE;
                            end
                        end

                        tcw_pkg::CMD_READ:
                        begin
                            rd_ok_next    = rd_in_range;
                            ram_req.re    = rd_in_range;
                            ram_req.raddr = pu_pos;
                            state_next    = S_DONE;
                        end

                        tcw_pkg::CMD_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            sweep_next = '0;
                            state_next = S_CLEAR;
                        end

                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCR_RD:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = sweep_reg + tcw_pkg::ROW_STEP;
                state_next    = S_SCR_WR;
            end

            S_SCR_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = sweep_reg;
                ram_req.wdata = ram_rdata;
                sweep_next    = sweep_reg + AW'(1);
                state_next    = (sweep_reg == tcw_pkg::COPY_LAST) ? S_SCR_BLK : S_SCR_RD;
            end

            S_SCR_BLK:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = sweep_reg;
                ram_req.wdata = tcw_pkg::BLANK_CELL;
                if (sweep_reg == tcw_pkg::LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end

            S_DONE:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.cursor_col  = 7'(col_reg);
                    out_data_next.cursor_row  = 5'(row_reg);
                    out_data_next.cursor_pos  = 11'(pu_pos);
                    out_data_next.scrolled    = scr_reg;
                    if (cmd_reg == tcw_pkg::CMD_READ && rd_ok_reg)
                    begin
                        out_data_next.cell_char = ram_rdata[7:0];
                        out_data_next.cell_attr = ram_rdata[15:8];
                    end
                    else
                    begin
                        out_data_next.cell_char = '0;
                        out_data_next.cell_attr = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            scr_reg       <= 1'b0;
            cmd_reg       <= tcw_pkg::CMD_PUT;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            attr_reg      <= tcw_pkg::ATTR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            scr_reg       <= scr_next;
            cmd_reg       <= cmd_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_checker.sv =====
`default_nettype none

module tcw_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire tcw_pkg::tcw_out_t out_data
);

    // A result that is not taken holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One item at a time: an accepted transfer closes the input for the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // A scroll always leaves the cursor at the start of the bottom row.
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.scrolled |->
            out_data.cursor_col == 7'd0 && out_data.cursor_row == 5'(tcw_pkg::ROWS - 1))
        else $error("scroll left cursor elsewhere");

    // The cursor column stays on the screen.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, out_data.cursor_col} < 8'(tcw_pkg::COLUMNS))
        else $error("cursor column off screen");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
